>>> design/iconv_pkg.sv
// shared constants, codes and types of the streaming convolution block
`default_nettype none

package iconv_pkg;

  // frame and kernel limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 2;
  localparam int KSIDE      = 2 * MAX_RADIUS + 1;
  localparam int NTAP       = KSIDE * KSIDE;
  localparam int LB_ROWS    = 2 * MAX_RADIUS;

  // field and counter widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = COL_W + 1;
  localparam int RAD_W  = 2;
  localparam int TOT_W  = COL_W + ROW_W + 1;
  localparam int POS_W  = TOT_W + 1;
  localparam int WIDX_W = $clog2(NTAP);
  localparam int PIX_W  = 16;
  localparam int WGT_W  = 16;
  localparam int PROD_W = PIX_W + WGT_W;
  localparam int PSUM_W = PROD_W + $clog2(KSIDE);
  localparam int SUM_W  = PROD_W + $clog2(NTAP);
  localparam int FRAC_W = 12;
  localparam int MAG_W  = 16;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // command codes
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd4;

  // clamped configuration seen by front and back
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [RAD_W-1:0] radius;
    logic [MAG_W-1:0] init_min;
    logic [MAG_W-1:0] init_max;
  } cfg_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic                    is_weight;
    logic [WIDX_W-1:0]       widx;
    logic signed [PIX_W-1:0] value;
    logic [COL_W-1:0]        col;
    logic                    emit;
    logic                    first;
    logic                    fend;
    logic [ROW_W-1:0]        orow;
    logic [COL_W-1:0]        ocol;
  } item_t;

endpackage

`default_nettype wire

>>> design/iconv_ram.sv
// generic single write port ram with registered read
`default_nettype none

module iconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/iconv_front.sv
// front end: accepts items, tracks frame positions and classifies each item
`default_nettype none

module iconv_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iconv_pkg::cfg_t                cfg_i,
  input  logic                           in_valid_i,
  input  logic [1:0]                     cmd_i,
  input  logic [2:0]                     weight_row_i,
  input  logic [2:0]                     weight_col_i,
  input  logic signed [15:0]             weight_value_i,
  input  logic signed [15:0]             pixel_value_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output iconv_pkg::item_t               item_o
);

  logic                                  accept;
  logic                                  is_weight;
  logic                                  is_sample;
  logic                                  wgt_ok;
  logic [2*iconv_pkg::DIM_W-1:0]         area;
  logic [iconv_pkg::TOT_W-1:0]           total;
  logic [iconv_pkg::POS_W-1:0]           delay;
  logic [iconv_pkg::POS_W-1:0]           pos_q;
  logic [iconv_pkg::COL_W-1:0]           in_col_q;
  logic [iconv_pkg::TOT_W-1:0]           out_pos_q;
  logic [iconv_pkg::ROW_W-1:0]           orow_q;
  logic [iconv_pkg::COL_W-1:0]           ocol_q;
  logic [iconv_pkg::TOT_W-1:0]           opos_inc;
  logic                                  emit;
  logic                                  fend;
  logic                                  col_wrap;
  logic                                  ocol_wrap;

  // classify the item
  always_comb begin
    is_weight = (cmd_i == iconv_pkg::CMD_WEIGHT);
    is_sample = (cmd_i inside {iconv_pkg::CMD_PIXEL, iconv_pkg::CMD_FLUSH});
  end

  assign wgt_ok = (weight_row_i < 3'(iconv_pkg::KSIDE)) &&
                  (weight_col_i < 3'(iconv_pkg::KSIDE));
  assign accept = in_valid_i && !q_full_i;
  assign push_o = accept && (is_sample || (is_weight && wgt_ok));

  // frame size and neighbourhood delay
  assign area  = (2*iconv_pkg::DIM_W)'(cfg_i.width) * (2*iconv_pkg::DIM_W)'(cfg_i.height);
  assign total = area[iconv_pkg::TOT_W-1:0];
  assign delay = iconv_pkg::POS_W'(cfg_i.radius) * iconv_pkg::POS_W'(cfg_i.width) +
                 iconv_pkg::POS_W'(cfg_i.radius);

  // position tests
  assign emit      = (pos_q >= delay);
  assign opos_inc  = out_pos_q + iconv_pkg::TOT_W'(1);
  assign fend      = (opos_inc >= total);
  assign col_wrap  = (({1'b0, in_col_q} + iconv_pkg::DIM_W'(1)) >= cfg_i.width);
  assign ocol_wrap = (({1'b0, ocol_q} + iconv_pkg::DIM_W'(1)) >= cfg_i.width);

  // input and output position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      in_col_q  <= '0;
      out_pos_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
    end else if (accept && is_sample) begin
      if (emit && fend) begin
        pos_q     <= '0;
        in_col_q  <= '0;
        out_pos_q <= '0;
        orow_q    <= '0;
        ocol_q    <= '0;
      end else begin
        pos_q    <= pos_q + iconv_pkg::POS_W'(1);
        in_col_q <= col_wrap ? '0 : in_col_q + iconv_pkg::COL_W'(1);
        if (emit) begin
          out_pos_q <= opos_inc;
          if (ocol_wrap) begin
            ocol_q <= '0;
            orow_q <= orow_q + iconv_pkg::ROW_W'(1);
          end else begin
            ocol_q <= ocol_q + iconv_pkg::COL_W'(1);
          end
        end
      end
    end
  end

  // item for the back end
  always_comb begin
    item_o.is_weight = is_weight;
    item_o.widx      = iconv_pkg::WIDX_W'(weight_row_i) * iconv_pkg::WIDX_W'(iconv_pkg::KSIDE) +
                       iconv_pkg::WIDX_W'(weight_col_i);
    if (is_weight) begin
      item_o.value = weight_value_i;
    end else if (cmd_i == iconv_pkg::CMD_PIXEL) begin
      item_o.value = pixel_value_i;
    end else begin
      item_o.value = '0;
    end
    item_o.col   = in_col_q;
    item_o.emit  = emit;
    item_o.first = (out_pos_q == '0);
    item_o.fend  = fend;
    item_o.orow  = orow_q;
    item_o.ocol  = ocol_q;
  end

endmodule

`default_nettype wire

>>> design/iconv_fifo.sv
// short item queue between front and back
`default_nettype none

module iconv_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  iconv_pkg::item_t item_i,
  input  logic             pop_i,
  output iconv_pkg::item_t head_o,
  output logic             full_o,
  output logic             empty_o
);

  iconv_pkg::item_t            mem_q [iconv_pkg::Q_DEPTH];
  logic [iconv_pkg::Q_PTR_W-1:0] wr_ptr_q;
  logic [iconv_pkg::Q_PTR_W-1:0] rd_ptr_q;
  logic [iconv_pkg::Q_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (iconv_pkg::Q_PTR_W + 1)'(iconv_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + iconv_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + iconv_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (iconv_pkg::Q_PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (iconv_pkg::Q_PTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/iconv_back.sv
// back end: line buffers, window, multiply-accumulate and running min/max
`default_nettype none

module iconv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iconv_pkg::cfg_t  cfg_i,
  input  logic             q_empty_i,
  input  iconv_pkg::item_t q_head_i,
  output logic             q_pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [15:0]      out_value_o,
  output logic [9:0]       out_row_o,
  output logic [9:0]       out_col_o,
  output logic             frame_end_o,
  output logic [15:0]      running_min_o,
  output logic [15:0]      running_max_o
);

  localparam int KS = iconv_pkg::KSIDE;
  localparam int NT = iconv_pkg::NTAP;
  localparam int LB = iconv_pkg::LB_ROWS;
  localparam int PW = iconv_pkg::PIX_W;

  logic adv;
  logic rd_en;
  logic wr_en;

  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  iconv_pkg::item_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;

  logic [PW-1:0]          lb_rd   [LB];
  logic signed [PW-1:0]   lb_wd   [LB];
  logic signed [PW-1:0]   lb_eff  [LB];
  logic signed [PW-1:0]   byp_data_q [LB];
  logic                   byp_q;
  logic signed [PW-1:0]   colvec  [KS];
  logic signed [PW-1:0]   win_q   [KS][KS];

  logic                   row_ok  [KS];
  logic                   col_ok  [KS];
  logic [iconv_pkg::RAD_W:0] two_r;
  logic signed [PW-1:0]   tap_d   [NT];
  logic signed [PW-1:0]   tap_q   [NT];
  logic signed [iconv_pkg::WGT_W-1:0]  wgt_q  [NT];
  logic signed [iconv_pkg::PROD_W-1:0] prod_q [NT];
  logic signed [iconv_pkg::PSUM_W-1:0] psum_d [KS];
  logic signed [iconv_pkg::PSUM_W-1:0] psum_q [KS];
  logic signed [iconv_pkg::SUM_W-1:0]  sum_d;
  logic signed [iconv_pkg::SUM_W-1:0]  sum_q;

  logic [iconv_pkg::SUM_W-1:0]          abs_v;
  logic [iconv_pkg::SUM_W-iconv_pkg::FRAC_W-1:0] quot;
  logic [iconv_pkg::MAG_W-1:0] mag;
  logic                        fire;
  logic [iconv_pkg::MAG_W-1:0] base_min, base_max, min_d, max_d;

  logic                        out_valid_q;
  logic [iconv_pkg::MAG_W-1:0] out_value_q, min_q, max_q;
  logic [iconv_pkg::ROW_W-1:0] out_row_q;
  logic [iconv_pkg::COL_W-1:0] out_col_q;
  logic                        fend_q;

  // the whole back pipeline moves when the output register can take an item
  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && !q_empty_i;
  assign rd_en   = q_pop_o && !q_head_i.is_weight;
  assign wr_en   = adv && s1_v_q && !s1_q.is_weight;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= q_pop_o;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  // stage items
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= q_head_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
      s5_q <= s4_q;
      s6_q <= s5_q;
    end
  end

  // line buffers: row k holds the samples k+1 rows back, one column per address
  for (genvar k = 0; k < LB; k++) begin : g_lb
    iconv_ram #(
      .WIDTH (PW),
      .DEPTH (iconv_pkg::MAX_WIDTH)
    ) u_lb (
      .clk_i   (clk_i),
      .we_i    (wr_en),
      .waddr_i (s1_q.col),
      .wdata_i (lb_wd[k]),
      .re_i    (rd_en),
      .raddr_i (q_head_i.col),
      .rdata_o (lb_rd[k])
    );
    assign lb_eff[k] = byp_q ? byp_data_q[k] : $signed(lb_rd[k]);
    if (k == 0) begin : g_first
      assign lb_wd[k] = s1_q.value;
    end else begin : g_next
      assign lb_wd[k] = lb_eff[k-1];
    end
  end

  // bypass when a read hits the column being written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en) begin
      byp_q <= wr_en && (q_head_i.col == s1_q.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      byp_data_q <= lb_wd;
    end
  end

  // new column entering the window
  always_comb begin
    colvec[0] = s1_q.value;
    for (int k = 1; k < KS; k++) begin
      colvec[k] = lb_eff[k-1];
    end
  end

  // window shift: first index is column age, second is row age
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_q[0] <= colvec;
      for (int j = 1; j < KS; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // frame edge tests for each kernel row and column
  assign two_r = {cfg_i.radius, 1'b0};

  for (genvar a = 0; a < KS; a++) begin : g_edge
    logic [iconv_pkg::ROW_W+1:0] rr;
    logic [iconv_pkg::COL_W+1:0] cc;
    assign rr = {2'b00, s2_q.orow} + (iconv_pkg::ROW_W + 2)'(a) -
                (iconv_pkg::ROW_W + 2)'(cfg_i.radius);
    assign cc = {2'b00, s2_q.ocol} + (iconv_pkg::COL_W + 2)'(a) -
                (iconv_pkg::COL_W + 2)'(cfg_i.radius);
    assign row_ok[a] = !rr[iconv_pkg::ROW_W+1] && (rr < {1'b0, cfg_i.height}) &&
                       ((iconv_pkg::RAD_W + 1)'(a) <= two_r);
    assign col_ok[a] = !cc[iconv_pkg::COL_W+1] && (cc < {1'b0, cfg_i.width}) &&
                       ((iconv_pkg::RAD_W + 1)'(a) <= two_r);
  end

  // tap selection with zero padding outside the frame
  for (genvar a = 0; a < KS; a++) begin : g_tr
    for (genvar b = 0; b < KS; b++) begin : g_tc
      logic signed [PW-1:0] cand [iconv_pkg::MAX_RADIUS+1];
      for (genvar rv = 0; rv <= iconv_pkg::MAX_RADIUS; rv++) begin : g_rv
        if (a <= 2 * rv && b <= 2 * rv) begin : g_in
          assign cand[rv] = win_q[2*rv-b][2*rv-a];
        end else begin : g_out
          assign cand[rv] = '0;
        end
      end
      assign tap_d[a*KS+b] = (row_ok[a] && col_ok[b]) ? cand[cfg_i.radius] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tap_q <= tap_d;
    end
  end

  // weight store, written in order with the samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT; i++) begin
        wgt_q[i] <= '0;
      end
    end else if (adv && s3_v_q && s3_q.is_weight) begin
      wgt_q[s3_q.widx] <= s3_q.value;
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NT; i++) begin
        prod_q[i] <= tap_q[i] * wgt_q[i];
      end
    end
  end

  // row sums
  always_comb begin
    for (int a = 0; a < KS; a++) begin
      psum_d[a] = '0;
      for (int b = 0; b < KS; b++) begin
        psum_d[a] = psum_d[a] + iconv_pkg::PSUM_W'(prod_q[a*KS+b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      psum_q <= psum_d;
    end
  end

  // total sum
  always_comb begin
    sum_d = '0;
    for (int a = 0; a < KS; a++) begin
      sum_d = sum_d + iconv_pkg::SUM_W'(psum_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sum_d;
    end
  end

  // magnitude of the truncated quotient, saturated
  assign abs_v = sum_q[iconv_pkg::SUM_W-1] ? iconv_pkg::SUM_W'(-sum_q) : iconv_pkg::SUM_W'(sum_q);
  assign quot  = abs_v[iconv_pkg::SUM_W-1:iconv_pkg::FRAC_W];
  assign mag   = (|quot[iconv_pkg::SUM_W-iconv_pkg::FRAC_W-1:iconv_pkg::MAG_W]) ?
                 '1 : quot[iconv_pkg::MAG_W-1:0];
  assign fire  = s6_v_q && !s6_q.is_weight && s6_q.emit;

  // running min and max, seeded at the first output of a frame
  always_comb begin
    base_min = s6_q.first ? cfg_i.init_min : min_q;
    base_max = s6_q.first ? cfg_i.init_max : max_q;
    min_d    = base_min;
    max_d    = base_max;
    if (mag > base_max) begin
      max_d = mag;
    end else if (mag < base_min) begin
      min_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      min_q       <= '0;
      max_q       <= '0;
    end else if (adv) begin
      out_valid_q <= fire;
      if (fire) begin
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv && fire) begin
      out_value_q <= mag;
      out_row_q   <= s6_q.orow;
      out_col_q   <= s6_q.ocol;
      fend_q      <= s6_q.fend;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign frame_end_o   = fend_q;
  assign running_min_o = min_q;
  assign running_max_o = max_q;

endmodule

`default_nettype wire

>>> design/image_convolution_2d_zero_pad.sv
// top level of the streaming 2d convolution with zero padding
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i / in_stall_o cmd, weight_row, weight_col, weight_value,
//                                               pixel_value
//  out       source     out_valid_o/out_stall_i out_value, out_row, out_col, frame_end,
//                                               running_min, running_max
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; the result for a pixel
// follows the item that completes its neighbourhood through the queue, the six back
// stages (line buffer read, window, tap select, multiply, row sum, total sum) and the
// output register. reset clears counters, weights, queue and running min/max; line
// buffers hold no reset. a held result under stall freezes the back end; the front
// keeps taking items until the four entry queue is full.
`default_nettype none

module image_convolution_2d_zero_pad (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [2:0]                      weight_row_i,
  input  logic [2:0]                      weight_col_i,
  input  logic signed [15:0]              weight_value_i,
  input  logic signed [15:0]              pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [15:0]                     out_value_o,
  output logic [9:0]                      out_row_o,
  output logic [9:0]                      out_col_o,
  output logic                            frame_end_o,
  output logic [15:0]                     running_min_o,
  output logic [15:0]                     running_max_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [iconv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [iconv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [iconv_pkg::DIM_W-1:0] width_q, height_q;
  logic [iconv_pkg::RAD_W-1:0] radius_q;
  logic [iconv_pkg::MAG_W-1:0] init_min_q, init_max_q;
  iconv_pkg::cfg_t             cfg;
  logic                        push, pop, q_full, q_empty;
  iconv_pkg::item_t            push_item, head_item;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= iconv_pkg::DIM_W'(iconv_pkg::MAX_WIDTH);
      height_q   <= iconv_pkg::DIM_W'(iconv_pkg::MAX_HEIGHT);
      radius_q   <= iconv_pkg::RAD_W'(1);
      init_min_q <= '0;
      init_max_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        iconv_pkg::CFG_WIDTH:  width_q    <= cfg_data_i[iconv_pkg::DIM_W-1:0];
        iconv_pkg::CFG_HEIGHT: height_q   <= cfg_data_i[iconv_pkg::DIM_W-1:0];
        iconv_pkg::CFG_RADIUS: radius_q   <= cfg_data_i[iconv_pkg::RAD_W-1:0];
        iconv_pkg::CFG_MIN:    init_min_q <= cfg_data_i[iconv_pkg::MAG_W-1:0];
        iconv_pkg::CFG_MAX:    init_max_q <= cfg_data_i[iconv_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their working ranges
  always_comb begin
    if (width_q == '0) begin
      cfg.width = iconv_pkg::DIM_W'(1);
    end else if (width_q > iconv_pkg::DIM_W'(iconv_pkg::MAX_WIDTH)) begin
      cfg.width = iconv_pkg::DIM_W'(iconv_pkg::MAX_WIDTH);
    end else begin
      cfg.width = width_q;
    end
    if (height_q == '0) begin
      cfg.height = iconv_pkg::DIM_W'(1);
    end else if (height_q > iconv_pkg::DIM_W'(iconv_pkg::MAX_HEIGHT)) begin
      cfg.height = iconv_pkg::DIM_W'(iconv_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = height_q;
    end
    if (radius_q > iconv_pkg::RAD_W'(iconv_pkg::MAX_RADIUS)) begin
      cfg.radius = iconv_pkg::RAD_W'(iconv_pkg::MAX_RADIUS);
    end else begin
      cfg.radius = radius_q;
    end
    cfg.init_min = init_min_q;
    cfg.init_max = init_max_q;
  end

  assign in_stall_o = q_full;

  // front end
  iconv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .cmd_i          (cmd_i),
    .weight_row_i   (weight_row_i),
    .weight_col_i   (weight_col_i),
    .weight_value_i (weight_value_i),
    .pixel_value_i  (pixel_value_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  // item queue
  iconv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back end
  iconv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_head_i      (head_item),
    .q_pop_o       (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_value_o   (out_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_end_o   (frame_end_o),
    .running_min_o (running_min_o),
    .running_max_o (running_max_o)
  );

endmodule

`default_nettype wire

>>> design/iconv_checker.sv
// port level checks of the convolution block, bound to its top level
`default_nettype none

module iconv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] out_value_o,
  input logic [9:0]  out_row_o,
  input logic [9:0]  out_col_o,
  input logic        frame_end_o,
  input logic [15:0] running_min_o,
  input logic [15:0] running_max_o
);

  logic seen_end_q;

  // marks that the next output item opens a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_end_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      seen_end_q <= frame_end_o;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item withdrawn under stall");

  // a stalled result keeps its value and running min and max
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_value_o) && $stable(running_min_o) &&
                                   $stable(running_max_o))
    else $error("output item changed under stall");

  // each value lies at or under the running maximum it updated
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_value_o <= running_max_o))
    else $error("output value above running max");

  // a frame starts at its top left pixel
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_end_q |-> (out_row_o == '0) && (out_col_o == '0))
    else $error("frame does not start at row and column zero");

endmodule

bind image_convolution_2d_zero_pad iconv_checker u_iconv_checker (.*);

`default_nettype wire

>>> verif/image_convolution_2d_zero_pad_tb.sv
// self-checking testbench of the streaming 2d convolution with zero padding
`default_nettype none

module image_convolution_2d_zero_pad_tb;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RING       = 2 * iconv_pkg::MAX_RADIUS * iconv_pkg::MAX_WIDTH +
                              2 * iconv_pkg::MAX_RADIUS + 1;
  localparam int LIMIT      = 600000;
  localparam int SETTLE     = 24;
  localparam int HOLD_LEN   = 300;
  localparam int ITEM_GOAL  = 1950;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         wr;
    logic [2:0]         wc;
    logic signed [15:0] wv;
    logic signed [15:0] pv;
  } in_t;

  typedef struct packed {
    logic [15:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        fend;
    logic [15:0] rmin;
    logic [15:0] rmax;
  } px_t;

  typedef struct packed {
    in_t it;
    bit  has_exp;
    px_t exp_px;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd = iconv_pkg::CMD_PIXEL;
  logic [2:0] wrow = '0;
  logic [2:0] wcol = '0;
  logic signed [15:0] wval = '0;
  logic signed [15:0] pval = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic [15:0] out_value_o;
  logic [9:0] out_row_o, out_col_o;
  logic frame_end_o;
  logic [15:0] running_min_o, running_max_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [iconv_pkg::CFG_IDX_W-1:0] cfg_index = iconv_pkg::CFG_WIDTH;
  logic [iconv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  image_convolution_2d_zero_pad dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd),
    .weight_row_i  (wrow),
    .weight_col_i  (wcol),
    .weight_value_i(wval),
    .pixel_value_i (pval),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .out_value_o   (out_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_end_o   (frame_end_o),
    .running_min_o (running_min_o),
    .running_max_o (running_max_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // shadow registers and state of the convolution
  int unsigned reg_w = 1024, reg_h = 1024, reg_r = 1, reg_min = 0, reg_max = 0;
  logic signed [15:0] kern [iconv_pkg::NTAP];
  logic signed [15:0] ring [RING];
  int unsigned row_in = 0, col_in = 0, opos = 0, min_run = 0, max_run = 0;

  px_t pending_px[$];
  row_t tbl[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    foreach (kern[i]) kern[i] = '0;
    foreach (ring[i]) ring[i] = '0;
  end

  // expected output pixel for one accepted item
  function automatic bit conv_accept(input in_t it, output px_t res);
    int unsigned w, h, r, total, delay, pos, orow, ocol;
    int ri, dr, dc;
    longint rr, cc, acc;
    longint unsigned mag;
    res = '0;
    if (it.cmd == iconv_pkg::CMD_WEIGHT) begin
      if (it.wr < iconv_pkg::KSIDE && it.wc < iconv_pkg::KSIDE)
        kern[it.wr * iconv_pkg::KSIDE + it.wc] = it.wv;
      return 1'b0;
    end
    if (it.cmd == CMD_NONE) return 1'b0;
    w = reg_w < 1 ? 1 : (reg_w > iconv_pkg::MAX_WIDTH ? iconv_pkg::MAX_WIDTH : reg_w);
    h = reg_h < 1 ? 1 : (reg_h > iconv_pkg::MAX_HEIGHT ? iconv_pkg::MAX_HEIGHT : reg_h);
    r = reg_r > iconv_pkg::MAX_RADIUS ? iconv_pkg::MAX_RADIUS : reg_r;
    total = w * h;
    delay = r * w + r;
    pos = row_in * w + col_in;
    if (pos < total) ring[pos % RING] = (it.cmd == iconv_pkg::CMD_PIXEL) ? it.pv : 16'sd0;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (pos < delay) return 1'b0;
    orow = opos / w;
    ocol = opos % w;
    ri = int'(r);
    acc = 0;
    for (dr = -ri; dr <= ri; dr++) begin
      rr = longint'(orow) + dr;
      if (rr < 0 || rr >= longint'(h)) continue;
      for (dc = -ri; dc <= ri; dc++) begin
        cc = longint'(ocol) + dc;
        if (cc < 0 || cc >= longint'(w)) continue;
        acc += longint'(ring[(rr * w + cc) % RING]) *
               longint'(kern[(dr + ri) * iconv_pkg::KSIDE + dc + ri]);
      end
    end
    if (acc < 0) acc = -acc;
    acc = acc >>> 12;
    mag = acc > 65535 ? 65535 : acc;
    // seeds at frame start, then max before min
    if (opos == 0) begin
      min_run = reg_min;
      max_run = reg_max;
    end
    if (mag > max_run) max_run = mag;
    else if (mag < min_run) min_run = mag;
    res.value = mag[15:0];
    res.row = orow[9:0];
    res.col = ocol[9:0];
    res.fend = (opos + 1 >= total);
    res.rmin = min_run[15:0];
    res.rmax = max_run[15:0];
    if (res.fend) begin
      row_in = 0;
      col_in = 0;
      opos = 0;
    end else begin
      opos++;
    end
    return 1'b1;
  endfunction

  // one item over the input channel, with random gaps
  task automatic send_item(input in_t it, input bit has_exp, input px_t exp_px);
    bit acc;
    bit got;
    px_t res;
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    wrow <= it.wr;
    wcol <= it.wc;
    wval <= it.wv;
    pval <= it.pv;
    forever begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
      if (acc) break;
    end
    got = conv_accept(it, res);
    if (has_exp) pending_px.push_back(exp_px);
    else if (got) pending_px.push_back(res);
    if (it.cmd == iconv_pkg::CMD_PIXEL || it.cmd == iconv_pkg::CMD_FLUSH) pixels_sent++;
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic cfg_write(input logic [iconv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
      if (acc) break;
    end
    case (idx)
      iconv_pkg::CFG_WIDTH:  reg_w = {21'd0, data[10:0]};
      iconv_pkg::CFG_HEIGHT: reg_h = {21'd0, data[10:0]};
      iconv_pkg::CFG_RADIUS: reg_r = {30'd0, data[1:0]};
      iconv_pkg::CFG_MIN:    reg_min = {16'd0, data};
      iconv_pkg::CFG_MAX:    reg_max = {16'd0, data};
      default: ;
    endcase
  endtask

  // lets the block drain before registers change
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h, input int r, input int mn, input int mx);
    drain();
    cfg_write(iconv_pkg::CFG_WIDTH, w[15:0]);
    cfg_write(iconv_pkg::CFG_HEIGHT, h[15:0]);
    cfg_write(iconv_pkg::CFG_RADIUS, r[15:0]);
    cfg_write(iconv_pkg::CFG_MIN, mn[15:0]);
    cfg_write(iconv_pkg::CFG_MAX, mx[15:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] c, input int wr, input int wc, input int wv,
                         input int pv, input bit hx, input px_t e);
    row_t rw;
    rw.it = '{cmd: c, wr: wr[2:0], wc: wc[2:0], wv: wv[15:0], pv: pv[15:0]};
    rw.has_exp = hx;
    rw.exp_px = e;
    tbl.push_back(rw);
  endtask

  task automatic run_rows(input int lo, input int hi);
    for (int i = lo; i <= hi; i++) send_item(tbl[i].it, tbl[i].has_exp, tbl[i].exp_px);
  endtask

  function automatic logic [15:0] rnd_sample();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'h7FFF;
    if (k == 1) return 16'h8000;
    if (k == 2) return 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rnd_weight();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'h7FFF;
    if (k == 1) return 16'h8000;
    return 16'($urandom_range(0, 16383) - 8192);
  endfunction

  // result check against the oldest expectation
  always @(negedge clk_i) begin
    px_t seen, want;
    if (rst_ni && out_valid_o && !out_stall) begin
      seen = '{value: out_value_o, row: out_row_o, col: out_col_o, fend: frame_end_o,
               rmin: running_min_o, rmax: running_max_o};
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output pixel %p", seen);
      end else begin
        want = pending_px.pop_front();
        if (seen !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, seen);
        end
      end
    end
  end

  // receiver stalls, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= hold_left + 1;
      if (hold_left >= HOLD_LEN) hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  // overall time limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    px_t e;
    in_t it;
    int w, h, r, total, delay, nload, frame_no, wr_raw, hr_raw, mn, mx, wm, hm;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all weights zero after reset, so every output is zero
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 32767, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, -32768, 0, '0);
    add_row(iconv_pkg::CMD_FLUSH, 0, 0, 0, 0, 0, '0);
    e = '{value: 16'd0, row: 10'd0, col: 10'd0, fend: 1'b0, rmin: 16'd0, rmax: 16'd3};
    add_row(iconv_pkg::CMD_FLUSH, 0, 0, 0, 0, 1, e);
    e = '{value: 16'd0, row: 10'd0, col: 10'd1, fend: 1'b1, rmin: 16'd0, rmax: 16'd3};
    add_row(iconv_pkg::CMD_FLUSH, 0, 0, 0, 0, 1, e);
    // extreme weights, ignored indexes, unused command
    add_row(iconv_pkg::CMD_WEIGHT, 0, 0, 32767, 0, 0, '0);
    add_row(iconv_pkg::CMD_WEIGHT, 2, 2, -32768, 0, 0, '0);
    add_row(iconv_pkg::CMD_WEIGHT, 1, 1, 4096, 0, 0, '0);
    add_row(iconv_pkg::CMD_WEIGHT, 0, 2, -1, 0, 0, '0);
    add_row(iconv_pkg::CMD_WEIGHT, 5, 0, 1000, 0, 0, '0);
    add_row(iconv_pkg::CMD_WEIGHT, 0, 7, 1000, 0, 0, '0);
    add_row(CMD_NONE, 7, 7, -1, -1, 0, '0);
    // 3x3 frame with an early flush, then excess pixels and flushes
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 32767, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, -32768, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 1, 0, '0);
    add_row(iconv_pkg::CMD_FLUSH, 0, 0, 0, 0, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, -1, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 100, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, -32768, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 32767, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, 555, 0, '0);
    add_row(iconv_pkg::CMD_FLUSH, 0, 0, 0, 0, 0, '0);
    add_row(iconv_pkg::CMD_FLUSH, 0, 0, 0, 0, 0, '0);
    add_row(iconv_pkg::CMD_PIXEL, 0, 0, 0, -77, 0, '0);

    set_frame(2, 1, 1, 7, 3);
    run_rows(0, 4);
    set_frame(3, 3, 1, 65535, 0);
    run_rows(5, tbl.size() - 1);

    // random frames
    frame_no = 0;
    while (pixels_sent < ITEM_GOAL) begin
      frame_no++;
      wr_raw = $urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
      hr_raw = $urandom_range(1, 6);
      r = $urandom_range(0, 3);
      mn = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535);
      mx = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535);
      // clamped extremes of the frame registers
      if (frame_no == 2) begin
        wr_raw = 1500; hr_raw = 0; r = 0;
      end else if (frame_no == 5) begin
        wr_raw = 0; hr_raw = 5; r = 3;
      end else if (frame_no == 7) begin
        wr_raw = 2049; hr_raw = 2; r = 2;
      end else if (frame_no == 8) begin
        // large enough to fill the block during the long hold-off
        wr_raw = 12; hr_raw = 6;
      end
      calm = (frame_no >= 10 && frame_no <= 13);
      set_frame(wr_raw, hr_raw, r, mn, mx);
      if (frame_no == 8) hold_go = 1'b1;
      wm = wr_raw & 'h7FF;
      hm = hr_raw & 'h7FF;
      w = wm < 1 ? 1 : (wm > iconv_pkg::MAX_WIDTH ? iconv_pkg::MAX_WIDTH : wm);
      h = hm < 1 ? 1 : (hm > iconv_pkg::MAX_HEIGHT ? iconv_pkg::MAX_HEIGHT : hm);
      r = r > iconv_pkg::MAX_RADIUS ? iconv_pkg::MAX_RADIUS : r;
      total = w * h;
      delay = r * w + r;
      // fresh kernel taps before the frame
      nload = $urandom_range(2, 10);
      for (int i = 0; i < nload; i++) begin
        it = '{cmd: iconv_pkg::CMD_WEIGHT,
               wr: 3'($urandom_range(0, iconv_pkg::KSIDE - 1)),
               wc: 3'($urandom_range(0, iconv_pkg::KSIDE - 1)),
               wv: rnd_weight(), pv: rnd_sample()};
        send_item(it, 1'b0, '0);
      end
      for (int p = 0; p < total + delay; p++) begin
        // noise that causes nothing
        if ($urandom_range(0, 99) < 3) begin
          it = '{cmd: CMD_NONE, wr: 3'($urandom_range(0, 7)), wc: 3'($urandom_range(0, 7)),
                 wv: rnd_weight(), pv: rnd_sample()};
          send_item(it, 1'b0, '0);
        end else if ($urandom_range(0, 99) < 2) begin
          it = '{cmd: iconv_pkg::CMD_WEIGHT, wr: 3'($urandom_range(5, 7)),
                 wc: 3'($urandom_range(0, 7)), wv: rnd_weight(), pv: rnd_sample()};
          send_item(it, 1'b0, '0);
        end
        it = '{cmd: ($urandom_range(0, 99) < 6) ? iconv_pkg::CMD_FLUSH : iconv_pkg::CMD_PIXEL,
               wr: 3'($urandom_range(0, 7)), wc: 3'($urandom_range(0, 7)),
               wv: rnd_weight(), pv: rnd_sample()};
        if (p >= total && $urandom_range(0, 1) == 0) it.cmd = iconv_pkg::CMD_FLUSH;
        send_item(it, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // wait for the tail, then report
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/iconv_pkg.sv
design/iconv_ram.sv
design/iconv_front.sv
design/iconv_fifo.sv
design/iconv_back.sv
design/image_convolution_2d_zero_pad.sv
design/iconv_checker.sv
verif/image_convolution_2d_zero_pad_tb.sv
